/* src/lrbs_pkg.sv */
package lrbs_pkg;

    localparam int AREA_W  = 25;
    localparam int DIM_W   = 13;
    localparam int POS_W   = 12;
    localparam int LABEL_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    localparam logic [DIM_W-1:0] DIM_RESET = 13'd4096;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SIZE     = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [LABEL_W-1:0] label;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
    } req_t;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [DIM_W-1:0]  min_x;
        logic [POS_W-1:0]  max_x;
        logic [DIM_W-1:0]  min_y;
        logic [POS_W-1:0]  max_y;
        logic              large_enough;
    } rsp_t;

    // write controls into the label table
    typedef struct packed {
        logic upd_en;
        logic clr_en;
    } tbl_ctrl_t;

endpackage

/* src/lrbs_table.sv */
module lrbs_table
    import lrbs_pkg::*;
#(
    parameter int LABEL_COUNT = 256,
    parameter int COORD_BITS  = 12,
    localparam int IDX_W      = $clog2(LABEL_COUNT)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_idx,
    input  tbl_ctrl_t             ctrl,
    input  logic [IDX_W-1:0]      wr_idx,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    output logic                  cur_valid,
    output logic [AREA_W-1:0]     cur_count,
    output logic [COORD_BITS-1:0] cur_lx,
    output logic [COORD_BITS-1:0] cur_hx,
    output logic [COORD_BITS-1:0] cur_ly,
    output logic [COORD_BITS-1:0] cur_hy
);

    localparam int WORD_W = 1 + AREA_W + 4 * COORD_BITS;

    logic [WORD_W-1:0] mem [LABEL_COUNT];
    logic [WORD_W-1:0] rd_word_reg;
    logic [WORD_W-1:0] fwd_word_reg;
    logic              fwd_hit_reg;
    logic [WORD_W-1:0] cur_word;
    logic [WORD_W-1:0] wr_word;
    logic              wr_en;
    logic [AREA_W-1:0] cnt_inc;

    assign wr_en = ctrl.upd_en | ctrl.clr_en;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_word;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_idx];
        end
        fwd_word_reg <= wr_word;
    end

    // a read that lands on the entry being written sees the new word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_idx == rd_idx);
        end
    end

    assign cur_word = fwd_hit_reg ? fwd_word_reg : rd_word_reg;
    assign {cur_valid, cur_count, cur_lx, cur_hx, cur_ly, cur_hy} = cur_word;

    assign cnt_inc = (cur_count == {AREA_W{1'b1}}) ? cur_count : cur_count + 1'b1;

    always_comb
    begin
        if (ctrl.clr_en)
        begin
            wr_word = '0;
        end
        else if (!cur_valid)
        begin
            wr_word = {1'b1, AREA_W'(1), pos_x, pos_x, pos_y, pos_y};
        end
        else
        begin
            wr_word = {1'b1, cnt_inc,
                       (pos_x < cur_lx) ? pos_x : cur_lx,
                       (pos_x > cur_hx) ? pos_x : cur_hx,
                       (pos_y < cur_ly) ? pos_y : cur_ly,
                       (pos_y > cur_hy) ? pos_y : cur_hy};
        end
    end

endmodule

/* src/label_region_box_statistics.sv */
// label region box statistics: per-label area and bounding box in one table
// read path: an accepted read is registered in stage one with its table word, then in rsp_reg
// throughput: pixel updates one per cycle (read-modify-write with forwarding)
// with no sweep or rsp stall; a read blocks the next word (one output register)
// clear: busy in stage one and through the sweep, one table entry swept per cycle
// reset: async active low; a clearing sweep of the table runs before req_ready
module label_region_box_statistics
    import lrbs_pkg::*;
#(
    parameter int LABEL_COUNT = 256,
    parameter int COORD_BITS  = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(LABEL_COUNT);
    localparam int CW    = COORD_BITS;

    // configuration registers
    logic [AREA_W-1:0] min_size_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;

    // stage one: the word whose table entry is being read
    logic             s1_valid_reg;
    logic [1:0]       s1_cmd_reg;
    logic             s1_hit_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [CW-1:0]    s1_x_reg;
    logic [CW-1:0]    s1_y_reg;

    // clearing sweep, also run after reset
    logic             sweep_reg;
    logic [IDX_W-1:0] sweep_idx_reg;

    logic rsp_valid_reg;
    rsp_t rsp_reg;

    logic      accept;
    logic      s1_read;
    logic      s1_clear;
    logic      req_hit;
    tbl_ctrl_t tbl_ctrl;

    logic              cur_valid;
    logic [AREA_W-1:0] cur_count;
    logic [CW-1:0]     cur_lx;
    logic [CW-1:0]     cur_hx;
    logic [CW-1:0]     cur_ly;
    logic [CW-1:0]     cur_hy;
    logic              ent_ok;
    rsp_t              rsp_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_size_reg <= '0;
            width_reg    <= DIM_RESET;
            height_reg   <= DIM_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MIN_SIZE:     min_size_reg <= cfg_data[AREA_W-1:0];
                CFG_IMAGE_WIDTH:  width_reg    <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg   <= cfg_data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    assign s1_read  = s1_valid_reg && (s1_cmd_reg == CMD_READ);
    assign s1_clear = s1_valid_reg && (s1_cmd_reg == CMD_CLEAR);

    // a read holds off the next word so it always finds the output register free
    assign req_ready = !sweep_reg && !s1_read && !s1_clear
                       && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    // label 0 and labels past the table never update it
    assign req_hit = (req.label != '0) && (32'(req.label) < 32'(LABEL_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= req.cmd;
            s1_hit_reg <= req_hit;
            s1_idx_reg <= IDX_W'(req.label);
            s1_x_reg   <= CW'(req.pos_x);
            s1_y_reg   <= CW'(req.pos_y);
        end
    end

    // sweep writes an empty word to every entry, one per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b1;
            sweep_idx_reg <= '0;
        end
        else if (sweep_reg)
        begin
            if (sweep_idx_reg == IDX_W'(LABEL_COUNT - 1))
            begin
                sweep_reg <= 1'b0;
            end
            sweep_idx_reg <= sweep_idx_reg + 1'b1;
        end
        else if (s1_clear)
        begin
            sweep_reg     <= 1'b1;
            sweep_idx_reg <= '0;
        end
    end

    assign tbl_ctrl.upd_en = s1_valid_reg && (s1_cmd_reg == CMD_UPDATE) && s1_hit_reg;
    assign tbl_ctrl.clr_en = sweep_reg;

    lrbs_table #(
        .LABEL_COUNT (LABEL_COUNT),
        .COORD_BITS  (COORD_BITS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_idx    (IDX_W'(req.label)),
        .ctrl      (tbl_ctrl),
        .wr_idx    (sweep_reg ? sweep_idx_reg : s1_idx_reg),
        .pos_x     (s1_x_reg),
        .pos_y     (s1_y_reg),
        .cur_valid (cur_valid),
        .cur_count (cur_count),
        .cur_lx    (cur_lx),
        .cur_hx    (cur_hx),
        .cur_ly    (cur_ly),
        .cur_hy    (cur_hy)
    );

    // read result; an empty entry reports the box as width, 0, height, 0
    assign ent_ok = s1_hit_reg && cur_valid;

    always_comb
    begin
        rsp_next.area  = ent_ok ? cur_count : '0;
        rsp_next.min_x = (ent_ok && (17'(cur_lx) < 17'(width_reg)))
                         ? DIM_W'(cur_lx) : width_reg;
        rsp_next.max_x = ent_ok ? POS_W'(cur_hx) : '0;
        rsp_next.min_y = (ent_ok && (17'(cur_ly) < 17'(height_reg)))
                         ? DIM_W'(cur_ly) : height_reg;
        rsp_next.max_y = ent_ok ? POS_W'(cur_hy) : '0;
        rsp_next.large_enough = rsp_next.area > min_size_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_read)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_read)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
